// ===== hw/rtl/response_frame_parser_assert.svh =====
// Assertion macros for the response frame parser.
// No dependencies; the including module must have clock and reset in scope.
`ifndef RESPONSE_FRAME_PARSER_ASSERT_SVH
`define RESPONSE_FRAME_PARSER_ASSERT_SVH

// same-cycle implication
`define RFP_ASSERT_IMPLIES(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define RFP_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== hw/rtl/rfp_pkg.sv =====
// Package for the response frame parser: payload structs, phase codes,
// result kinds, register indexes and reset values. No dependencies.
package rfp_pkg;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       frame_end;
   } req_type;

   typedef struct packed {
      logic [1:0]  result_kind;
      logic [63:0] offset_value;
      logic [7:0]  message_byte;
      logic        success_flag;
      logic        malformed;
      logic        run_last;
   } rsp_type;

   typedef enum logic [3:0] {
      PH_VERSION = 4'd0,
      PH_SUCCESS = 4'd1,
      PH_KIND    = 4'd2,
      PH_HOFF    = 4'd3,
      PH_SLEN    = 4'd4,
      PH_SBYTES  = 4'd5,
      PH_COUNT   = 4'd6,
      PH_BOFF    = 4'd7,
      PH_DONE    = 4'd8
   } phase_type;

   localparam logic [1:0] KIND_MESSAGE = 2'd0;
   localparam logic [1:0] KIND_HOFFSET = 2'd1;
   localparam logic [1:0] KIND_BOFFSET = 2'd2;
   localparam logic [1:0] KIND_STATUS  = 2'd3;

   localparam logic [1:0] CSR_EXPECTED_VERSION = 2'd0;
   localparam logic [1:0] CSR_MAX_STRING_LEN   = 2'd1;
   localparam logic [1:0] CSR_MAX_OFFSET_COUNT = 2'd2;

   localparam logic [7:0]  RST_EXPECTED_VERSION = 8'd1;
   localparam logic [31:0] RST_MAX_STRING_LEN   = 32'd16777216;
   localparam logic [15:0] RST_MAX_OFFSET_COUNT = 16'd10000;

endpackage

// ===== hw/rtl/response_frame_parser.sv =====
// Response frame parser: byte-serial big-endian frame decoder with a
// two-entry result buffer. Depends on rfp_pkg and response_frame_parser_assert.svh.
//
// Usage:
//  - req_*: one frame byte per transaction, frame_end flags the last byte.
//  - rsp_*: result transactions (message byte, header offset, batch offset,
//    frame status); run_last marks the last result caused by a byte.
//  - csr_*: register writes (expected version, string length limit, offset
//    count limit); always ready, write only while the block is idle.
// Latency: a result appears on rsp_* the cycle after its byte is taken.
// Throughput: one byte per cycle while rsp_ready is high. A byte that causes two
// results (an offset or string byte that also ends the frame) fills both
// buffer entries, which holds req_ready low until the first of them drains.
// Reset: registers return to their defaults, the parser waits for a version
// byte and the result buffer empties.
// Stall: while rsp_ready is low, results stay in the buffer; req_ready stays
// high only while the buffer is empty.
`include "response_frame_parser_assert.svh"

module response_frame_parser
   import rfp_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  req_type     req_payload,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output rsp_type     rsp_payload,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_data
);

   logic [7:0]  exp_version_ff;
   logic [31:0] max_str_len_ff;
   logic [15:0] max_off_cnt_ff;

   phase_type   phase_ff, phase_in;
   logic [2:0]  idx_ff, idx_in;
   logic [63:0] acc_ff, acc_in;
   logic [31:0] str_left_ff, str_left_in;
   logic [15:0] off_left_ff, off_left_in;
   logic        error_ff, error_in;
   logic        success_ff, success_in;

   rsp_type     head_ff, head_in;
   rsp_type     tail_ff, tail_in;
   logic [1:0]  count_ff, count_in;

   logic        accept;
   logic        drain;
   logic [7:0]  in_byte;
   logic        in_end;
   logic [63:0] acc_shift;
   logic        field_done;
   logic        data_valid;
   rsp_type     data_res;
   rsp_type     status_res;
   logic        status_bad;

   assign in_byte   = req_payload.data_byte;
   assign in_end    = req_payload.frame_end;
   assign drain     = rsp_valid && rsp_ready;
   assign req_ready = (count_ff == 2'd0) || ((count_ff == 2'd1) && rsp_ready);
   assign accept    = req_valid && req_ready;
   assign csr_ready = 1'b1;
   assign rsp_valid = (count_ff != 2'd0);
   assign rsp_payload = head_ff;

   assign acc_shift  = {acc_ff[55:0], in_byte};
   assign field_done = (((phase_ff == PH_HOFF) || (phase_ff == PH_BOFF)) && (idx_ff == 3'd7))
                    || (((phase_ff == PH_SLEN) || (phase_ff == PH_COUNT)) && (idx_ff == 3'd3));

   // next parse state for the byte on req_payload
   always_comb begin
      phase_in    = phase_ff;
      idx_in      = idx_ff;
      acc_in      = acc_ff;
      str_left_in = str_left_ff;
      off_left_in = off_left_ff;
      error_in    = error_ff;
      success_in  = success_ff;
      if (!error_ff) begin
         if (field_done) begin
            idx_in = 3'd0;
         end else begin
            idx_in = idx_ff + 3'd1;
         end
         case (phase_ff)
            PH_VERSION: begin
               idx_in = idx_ff;
               if (in_byte != exp_version_ff) begin
                  error_in = 1'b1;
               end else begin
                  phase_in = PH_SUCCESS;
               end
            end
            PH_SUCCESS: begin
               idx_in     = idx_ff;
               success_in = (in_byte != 8'd0);
               phase_in   = PH_KIND;
            end
            PH_KIND: begin
               idx_in   = 3'd0;
               acc_in   = 64'd0;
               phase_in = PH_HOFF;
            end
            PH_HOFF: begin
               acc_in = field_done ? 64'd0 : acc_shift;
               if (field_done) begin
                  phase_in = PH_SLEN;
               end
            end
            PH_SLEN: begin
               acc_in = field_done ? 64'd0 : acc_shift;
               if (field_done) begin
                  if (acc_shift[31:0] > max_str_len_ff) begin
                     error_in = 1'b1;
                  end else if (acc_shift[31:0] == 32'd0) begin
                     phase_in = PH_COUNT;
                  end else begin
                     str_left_in = acc_shift[31:0];
                     phase_in    = PH_SBYTES;
                  end
               end
            end
            PH_SBYTES: begin
               idx_in      = idx_ff;
               str_left_in = str_left_ff - 32'd1;
               if (str_left_ff == 32'd1) begin
                  phase_in = PH_COUNT;
               end
            end
            PH_COUNT: begin
               acc_in = field_done ? 64'd0 : acc_shift;
               if (field_done) begin
                  if (acc_shift[31:0] > {16'd0, max_off_cnt_ff}) begin
                     error_in = 1'b1;
                  end else if (acc_shift[31:0] == 32'd0) begin
                     phase_in = PH_DONE;
                  end else begin
                     off_left_in = acc_shift[15:0];
                     phase_in    = PH_BOFF;
                  end
               end
            end
            PH_BOFF: begin
               acc_in = field_done ? 64'd0 : acc_shift;
               if (field_done) begin
                  off_left_in = off_left_ff - 16'd1;
                  if (off_left_ff == 16'd1) begin
                     phase_in = PH_DONE;
                  end
               end
            end
            default: begin
               idx_in   = idx_ff;
               error_in = 1'b1;
            end
         endcase
      end
   end

   // results caused by the byte on req_payload
   always_comb begin
      data_valid = 1'b0;
      data_res   = '0;
      data_res.run_last = !in_end;
      if (!error_ff) begin
         case (phase_ff)
            PH_HOFF: begin
               data_valid = field_done;
               data_res.result_kind  = KIND_HOFFSET;
               data_res.offset_value = acc_shift;
            end
            PH_BOFF: begin
               data_valid = field_done;
               data_res.result_kind  = KIND_BOFFSET;
               data_res.offset_value = acc_shift;
            end
            PH_SBYTES: begin
               data_valid = 1'b1;
               data_res.result_kind  = KIND_MESSAGE;
               data_res.message_byte = in_byte;
            end
            default: begin
               data_valid = 1'b0;
            end
         endcase
      end
      status_bad = error_in || (phase_in != PH_DONE);
      status_res = '0;
      status_res.result_kind  = KIND_STATUS;
      status_res.success_flag = success_in && !status_bad;
      status_res.malformed    = status_bad;
      status_res.run_last     = 1'b1;
   end

   // two-entry result buffer
   always_comb begin
      head_in  = head_ff;
      tail_in  = tail_ff;
      count_in = count_ff;
      if (accept) begin
         head_in  = data_valid ? data_res : status_res;
         tail_in  = status_res;
         count_in = {1'b0, data_valid} + {1'b0, in_end};
      end else if (drain && (count_ff == 2'd2)) begin
         head_in  = tail_ff;
         count_in = 2'd1;
      end else if (drain) begin
         count_in = 2'd0;
      end
   end

   always_ff @(posedge clock) begin
      head_ff <= head_in;
      tail_ff <= tail_in;
      if (reset) begin
         count_ff       <= 2'd0;
         phase_ff       <= PH_VERSION;
         idx_ff         <= 3'd0;
         acc_ff         <= 64'd0;
         str_left_ff    <= 32'd0;
         off_left_ff    <= 16'd0;
         error_ff       <= 1'b0;
         success_ff     <= 1'b0;
         exp_version_ff <= RST_EXPECTED_VERSION;
         max_str_len_ff <= RST_MAX_STRING_LEN;
         max_off_cnt_ff <= RST_MAX_OFFSET_COUNT;
      end else begin
         count_ff <= count_in;
         if (accept && in_end) begin
            phase_ff    <= PH_VERSION;
            idx_ff      <= 3'd0;
            acc_ff      <= 64'd0;
            str_left_ff <= 32'd0;
            off_left_ff <= 16'd0;
            error_ff    <= 1'b0;
            success_ff  <= 1'b0;
         end else if (accept) begin
            phase_ff    <= phase_in;
            idx_ff      <= idx_in;
            acc_ff      <= acc_in;
            str_left_ff <= str_left_in;
            off_left_ff <= off_left_in;
            error_ff    <= error_in;
            success_ff  <= success_in;
         end
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_EXPECTED_VERSION: exp_version_ff <= csr_data[7:0];
               CSR_MAX_STRING_LEN:   max_str_len_ff <= csr_data;
               CSR_MAX_OFFSET_COUNT: max_off_cnt_ff <= csr_data[15:0];
               default: begin
               end
            endcase
         end
      end
   end

   `RFP_ASSERT_IMPLIES(a_count_range, 1'b1, count_ff != 2'd3, "result buffer overfilled")
   `RFP_ASSERT_IMPLIES(a_nonlast_queued, rsp_valid && !rsp_payload.run_last,
      count_ff == 2'd2, "non-last result without a queued follower")
   `RFP_ASSERT_IMPLIES(a_status_last, rsp_valid && (rsp_payload.result_kind == KIND_STATUS),
      rsp_payload.run_last && !(rsp_payload.malformed && rsp_payload.success_flag),
      "bad status result")
   `RFP_ASSERT_NEXT(a_frame_cleared, accept && in_end,
      (phase_ff == PH_VERSION) && !error_ff && !success_ff, "frame state not cleared")

endmodule

// ===== verif/response_frame_parser_test.sv =====
// Self-checking testbench for response_frame_parser: random and directed frames,
// a built-in frame decoder that predicts every result, and register sweeps.
// Depends on rfp_pkg and the response_frame_parser RTL.
module response_frame_parser_test;
   import rfp_pkg::*;

   localparam logic [1:0] CSR_SPARE_INDEX = 2'd3;

   logic        clock;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   req_type     req_payload = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   rsp_type     rsp_payload;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [1:0]  csr_index = '0;
   logic [31:0] csr_data = '0;

   response_frame_parser DUT (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_data    (csr_data)
   );

   req_type     frame_bytes[$];
   rsp_type     due_results[$];

   logic [7:0]  cfg_version;
   logic [31:0] cfg_str_max;
   logic [15:0] cfg_cnt_max;

   phase_type   p_phase;
   logic [2:0]  p_idx;
   logic [63:0] p_acc;
   logic [31:0] p_str_left;
   logic [15:0] p_offs_left;
   bit          p_err;
   bit          p_succ;

   int          errors = 0;
   int          bytes_queued = 0;
   int          frames_made = 0;
   int          results_seen = 0;
   int          csr_writes = 0;
   int          send_gap = 0;
   int          stall_left = 0;
   int          hold_left = 0;
   bit          hold_done = 1'b0;
   bit          calm = 1'b0;

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      #2000000;
      $display("Regression FAIL");
      $finish;
   end

   function automatic void clear_parse();
      p_phase = PH_VERSION;
      p_idx = '0;
      p_acc = '0;
      p_str_left = '0;
      p_offs_left = '0;
      p_err = 1'b0;
      p_succ = 1'b0;
   endfunction

   function automatic bit shift_in(input logic [7:0] b, input int unsigned n);
      p_acc = {p_acc[55:0], b};
      if (p_idx + 1 >= n) begin
         p_idx = '0;
         return 1'b1;
      end
      p_idx = p_idx + 3'd1;
      return 1'b0;
   endfunction

   function automatic rsp_type make_result(input logic [1:0] kind, input logic [63:0] off,
                                           input logic [7:0] mbyte, input logic succ,
                                           input logic bad);
      rsp_type r;
      r.result_kind = kind;
      r.offset_value = off;
      r.message_byte = mbyte;
      r.success_flag = succ;
      r.malformed = bad;
      r.run_last = 1'b0;
      return r;
   endfunction

   function automatic void decode_byte(input req_type item);
      rsp_type     outs[$];
      logic [31:0] v;
      bit          bad;
      if (!p_err) begin
         case (p_phase)
            PH_VERSION: begin
               if (item.data_byte != cfg_version) p_err = 1'b1;
               else p_phase = PH_SUCCESS;
            end
            PH_SUCCESS: begin
               p_succ = (item.data_byte != 8'd0);
               p_phase = PH_KIND;
            end
            PH_KIND: begin
               p_idx = '0;
               p_acc = '0;
               p_phase = PH_HOFF;
            end
            PH_HOFF: begin
               if (shift_in(item.data_byte, 8)) begin
                  outs.insert(outs.size(),
                              make_result(KIND_HOFFSET, p_acc, 8'd0, 1'b0, 1'b0));
                  p_acc = '0;
                  p_phase = PH_SLEN;
               end
            end
            PH_SLEN: begin
               if (shift_in(item.data_byte, 4)) begin
                  v = p_acc[31:0];
                  p_acc = '0;
                  if (v > cfg_str_max) p_err = 1'b1;
                  else if (v == 32'd0) p_phase = PH_COUNT;
                  else begin
                     p_str_left = v;
                     p_phase = PH_SBYTES;
                  end
               end
            end
            PH_SBYTES: begin
               outs.insert(outs.size(),
                           make_result(KIND_MESSAGE, 64'd0, item.data_byte, 1'b0, 1'b0));
               p_str_left = p_str_left - 32'd1;
               if (p_str_left == 32'd0) p_phase = PH_COUNT;
            end
            PH_COUNT: begin
               if (shift_in(item.data_byte, 4)) begin
                  v = p_acc[31:0];
                  p_acc = '0;
                  if (v > {16'd0, cfg_cnt_max}) p_err = 1'b1;
                  else if (v == 32'd0) p_phase = PH_DONE;
                  else begin
                     p_offs_left = v[15:0];
                     p_phase = PH_BOFF;
                  end
               end
            end
            PH_BOFF: begin
               if (shift_in(item.data_byte, 8)) begin
                  outs.insert(outs.size(),
                              make_result(KIND_BOFFSET, p_acc, 8'd0, 1'b0, 1'b0));
                  p_acc = '0;
                  p_offs_left = p_offs_left - 16'd1;
                  if (p_offs_left == 16'd0) p_phase = PH_DONE;
               end
            end
            default: p_err = 1'b1;
         endcase
      end
      if (item.frame_end) begin
         bad = p_err || (p_phase != PH_DONE);
         outs.insert(outs.size(),
                     make_result(KIND_STATUS, 64'd0, 8'd0, p_succ && !bad, bad));
         clear_parse();
      end
      if (outs.size() != 0) outs[outs.size() - 1].run_last = 1'b1;
      foreach (outs[i]) due_results.insert(due_results.size(), outs[i]);
   endfunction

   function automatic void check_field(input string name, input logic [63:0] want,
                                       input logic [63:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %h actual %h", $time, name, want, got);
         errors++;
      end
   endfunction

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         send_gap <= 0;
         clear_parse();
      end else begin
         if (req_valid && req_ready) decode_byte(req_payload);
         if (!req_valid || req_ready) begin
            if (send_gap != 0) begin
               send_gap <= send_gap - 1;
               req_valid <= 1'b0;
            end else if (frame_bytes.size() != 0) begin
               req_payload <= frame_bytes.pop_front();
               req_valid <= 1'b1;
               if (!calm && $urandom_range(0, 9) == 0) send_gap <= $urandom_range(1, 17);
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // receiver backpressure, including one long hold-off while bytes are pending
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         stall_left <= 0;
         hold_left <= 0;
         hold_done <= 1'b0;
      end else if (hold_left != 0) begin
         rsp_ready <= 1'b0;
         hold_left <= hold_left - 1;
      end else if (!hold_done && frame_bytes.size() > 100) begin
         hold_done <= 1'b1;
         hold_left <= 400;
         rsp_ready <= 1'b0;
      end else if (stall_left != 0) begin
         rsp_ready <= 1'b0;
         stall_left <= stall_left - 1;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
         rsp_ready <= 1'b0;
         stall_left <= $urandom_range(0, 16);
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // monitor
   always @(posedge clock) begin : monitor
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         results_seen <= results_seen + 1;
         if (due_results.size() == 0) begin
            $display("%0t: unexpected transaction, expected none actual %h", $time,
                     rsp_payload);
            errors++;
         end else begin
            want = due_results.pop_front();
            check_field("result_kind", 64'(want.result_kind),
                        64'(rsp_payload.result_kind));
            check_field("offset_value", want.offset_value, rsp_payload.offset_value);
            check_field("message_byte", 64'(want.message_byte),
                        64'(rsp_payload.message_byte));
            check_field("success_flag", 64'(want.success_flag),
                        64'(rsp_payload.success_flag));
            check_field("malformed", 64'(want.malformed), 64'(rsp_payload.malformed));
            check_field("run_last", 64'(want.run_last), 64'(rsp_payload.run_last));
         end
      end
   end

   // register shadow
   always @(posedge clock) begin
      if (reset) begin
         cfg_version <= RST_EXPECTED_VERSION;
         cfg_str_max <= RST_MAX_STRING_LEN;
         cfg_cnt_max <= RST_MAX_OFFSET_COUNT;
      end else if (csr_valid && csr_ready) begin
         csr_writes <= csr_writes + 1;
         case (csr_index)
            CSR_EXPECTED_VERSION: cfg_version <= csr_data[7:0];
            CSR_MAX_STRING_LEN:   cfg_str_max <= csr_data;
            CSR_MAX_OFFSET_COUNT: cfg_cnt_max <= csr_data[15:0];
            default: ;
         endcase
      end
   end

   task automatic write_csr(input logic [1:0] index, input logic [31:0] data);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data <= data;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      @(negedge clock);
   endtask

   task automatic wait_idle();
      do @(negedge clock);
      while (frame_bytes.size() != 0 || req_valid || due_results.size() != 0);
      repeat (4) @(negedge clock);
   endtask

   function automatic void add_be(ref logic [7:0] fb[$], input logic [63:0] v, input int n);
      for (int i = n - 1; i >= 0; i--) fb.insert(fb.size(), v[i*8 +: 8]);
   endfunction

   function automatic void enqueue(ref logic [7:0] fb[$], input bit noisy);
      req_type item;
      foreach (fb[i]) begin
         item.data_byte = fb[i];
         item.frame_end = (i == fb.size() - 1) || (noisy && $urandom_range(0, 2) == 0);
         frame_bytes.insert(frame_bytes.size(), item);
      end
      bytes_queued += fb.size();
      frames_made++;
   endfunction

   function automatic logic [63:0] pick_offset();
      case ($urandom_range(0, 9))
         0: return 64'd0;
         1: return '1;
         default: return {$urandom, $urandom};
      endcase
   endfunction

   function automatic void random_frame();
      logic [7:0]  fb[$];
      logic [31:0] len_field;
      logic [31:0] cnt_field;
      int          mode;
      int          slen;
      int          cnt;
      int          cut;
      mode = $urandom_range(0, 99);
      slen = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      cnt = $urandom_range(0, 4);
      if (slen > cfg_str_max) slen = cfg_str_max;
      if (cnt > cfg_cnt_max) cnt = int'(cfg_cnt_max);
      len_field = slen;
      cnt_field = cnt;
      if (mode >= 88 && mode < 94) begin
         if (cfg_str_max != 32'hFFFF_FFFF && $urandom_range(0, 1) == 1)
            len_field = ($urandom_range(0, 1) == 1) ? 32'hFFFF_FFFF : cfg_str_max + 32'd1;
         else
            cnt_field = ($urandom_range(0, 1) == 1) ? ($urandom | 32'h0001_0000)
                                                    : {16'd0, cfg_cnt_max} + 32'd1;
      end
      if (mode >= 65 && mode < 73)
         fb.insert(fb.size(), cfg_version ^ 8'($urandom_range(1, 255)));
      else fb.insert(fb.size(), cfg_version);
      fb.insert(fb.size(), ($urandom_range(0, 1) == 1) ? 8'd0 : 8'($urandom_range(0, 255)));
      fb.insert(fb.size(), 8'($urandom_range(0, 255)));
      add_be(fb, pick_offset(), 8);
      add_be(fb, {32'd0, len_field}, 4);
      for (int i = 0; i < slen; i++) fb.insert(fb.size(), 8'($urandom_range(0, 255)));
      add_be(fb, {32'd0, cnt_field}, 4);
      for (int i = 0; i < cnt; i++) add_be(fb, pick_offset(), 8);
      if (mode >= 73 && mode < 81) begin
         // frame ends early
         cut = $urandom_range(1, fb.size() - 1);
         while (fb.size() > cut) void'(fb.pop_back());
      end else if (mode >= 81 && mode < 88) begin
         repeat ($urandom_range(1, 3)) fb.insert(fb.size(), 8'($urandom_range(0, 255)));
      end else if (mode >= 94) begin
         fb.delete();
         repeat ($urandom_range(1, 6)) fb.insert(fb.size(), 8'($urandom_range(0, 255)));
      end
      enqueue(fb, mode >= 94);
   endfunction

   task automatic run_random(input int n);
      int start;
      start = bytes_queued;
      while (bytes_queued - start < n) random_frame();
      wait_idle();
   endtask

   initial begin : main
      logic [7:0] fb[$];
      int         waited;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // shortest well-formed frame, all-ones header offset
      fb.insert(fb.size(), RST_EXPECTED_VERSION);
      fb.insert(fb.size(), 8'hFF);
      fb.insert(fb.size(), 8'h00);
      add_be(fb, '1, 8);
      add_be(fb, 64'd0, 4);
      add_be(fb, 64'd0, 4);
      enqueue(fb, 1'b0);
      // wrong version, then end right after a good version byte
      fb.delete();
      fb.insert(fb.size(), 8'h00);
      enqueue(fb, 1'b0);
      fb.delete();
      fb.insert(fb.size(), RST_EXPECTED_VERSION);
      enqueue(fb, 1'b0);
      run_random(300);

      write_csr(CSR_EXPECTED_VERSION, 32'd0);
      write_csr(CSR_MAX_STRING_LEN, 32'd0);
      write_csr(CSR_MAX_OFFSET_COUNT, 32'd0);
      run_random(300);

      write_csr(CSR_EXPECTED_VERSION, 32'h0000_00FF);
      write_csr(CSR_MAX_STRING_LEN, 32'hFFFF_FFFF);
      write_csr(CSR_MAX_OFFSET_COUNT, 32'h0000_FFFF);
      write_csr(CSR_SPARE_INDEX, $urandom);
      run_random(300);

      write_csr(CSR_EXPECTED_VERSION, $urandom);
      write_csr(CSR_MAX_STRING_LEN, $urandom_range(0, 10));
      write_csr(CSR_MAX_OFFSET_COUNT, {16'($urandom), 16'($urandom_range(0, 6))});
      run_random(300);

      calm = 1'b1;
      write_csr(CSR_EXPECTED_VERSION, $urandom);
      write_csr(CSR_MAX_STRING_LEN, $urandom_range(1, 6));
      write_csr(CSR_MAX_OFFSET_COUNT, $urandom_range(1, 3));
      run_random(300);

      waited = 0;
      while (due_results.size() != 0 && waited < 20000) begin
         @(negedge clock);
         waited++;
      end
      repeat (8) @(negedge clock);
      if (due_results.size() != 0) begin
         $display("%0t: %0d results never arrived, expected %h actual none", $time,
                  due_results.size(), due_results[0]);
         errors++;
      end
      $display("Sent %0d frames (%0d bytes), checked %0d results over %0d register writes,",
               frames_made, bytes_queued, results_seen, csr_writes);
      $display("with malformed, truncated, trailing and noise frames at five settings.");
      if (errors == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
+incdir+hw/rtl
hw/rtl/rfp_pkg.sv
hw/rtl/response_frame_parser.sv
verif/response_frame_parser_test.sv
